// File: rtl/sws_pkg.sv
package sws_pkg;

   // event codes on the request channel
   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_IGNORE  = 2'd3
   } operation_type;

   typedef enum logic [1:0] {
      TIMER_NONE    = 2'd0,
      TIMER_START   = 2'd1,
      TIMER_STOP    = 2'd2,
      TIMER_RESTART = 2'd3
   } timer_action_type;

   typedef enum logic [1:0] {
      ACK_NONE = 2'd0,
      ACK_NEW  = 2'd1,
      ACK_DUP  = 2'd2
   } ack_kind_type;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int ACK_W      = 3;
   localparam int TX_SEQ_W   = 3;
   localparam int WIN_W      = 3;
   localparam int DUP_W      = 2;

   // duplicate ack handling
   localparam logic [DUP_W-1:0] DUP_RESET = 2'd1;
   localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

   // window size after reset
   localparam logic [WIN_W-1:0] WIN_RESET = 3'd4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // result fields other than the payload word
   typedef struct packed {
      logic                  accepted;
      logic                  transmit;
      logic [TX_SEQ_W-1:0]   tx_sequence;
      timer_action_type      timer_action;
      ack_kind_type          ack_kind;
      logic                  fast_retransmit;
   } result_type;

endpackage

// File: rtl/sws_req_if.sv
interface sws_req_if #(parameter int PAYLOAD_BITS = 64);
   logic                    valid;
   logic                    ready;
   logic [1:0]              operation;
   logic [PAYLOAD_BITS-1:0] payload_word;
   logic [2:0]              ack_number;
   logic                    checksum_ok;

   modport source (output valid, output operation, output payload_word,
                   output ack_number, output checksum_ok, input ready);
   modport sink (input valid, input operation, input payload_word,
                 input ack_number, input checksum_ok, output ready);
endinterface

// File: rtl/sws_rsp_if.sv
interface sws_rsp_if #(parameter int PAYLOAD_BITS = 64);
   logic                    valid;
   logic                    ready;
   logic                    accepted;
   logic                    transmit;
   logic [2:0]              tx_sequence;
   logic [PAYLOAD_BITS-1:0] tx_payload;
   logic [1:0]              timer_action;
   logic [1:0]              ack_kind;
   logic                    fast_retransmit;

   modport source (output valid, output accepted, output transmit, output tx_sequence,
                   output tx_payload, output timer_action, output ack_kind,
                   output fast_retransmit, input ready);
   modport sink (input valid, input accepted, input transmit, input tx_sequence,
                 input tx_payload, input timer_action, input ack_kind,
                 input fast_retransmit, output ready);
endinterface

// File: rtl/sws_csr_if.sv
interface sws_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface

// File: rtl/sliding_window_sender.sv
// Path: a request passes the front-stage register, the queue and the output register.
// Throughput: one request per cycle while the queue has room; the window state update plus
// one packet store access per transaction form the feedback loop in the front stage.
// Reset: synchronous, sets window base, next sequence and duplicate count to one, window size
// to four, and clears all queue and handshake state. The packet store is not cleared; no clearing pass.
module sliding_window_sender #(
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   sws_req_if.sink    req_if,
   sws_csr_if.sink    csr_if,
   sws_rsp_if.source  rsp_if
);
   import sws_pkg::*;

   localparam int SEQ_W = $clog2(SEQ_SPACE);

   logic                    ram_we;
   logic [SEQ_W-1:0]        ram_waddr;
   logic [PAYLOAD_BITS-1:0] ram_wdata;
   logic                    ram_re;
   logic [SEQ_W-1:0]        ram_raddr;
   logic [PAYLOAD_BITS-1:0] ram_rdata;
   logic                    push;
   result_type              push_result;
   logic [PAYLOAD_BITS-1:0] push_payload;
   logic                    pop;
   logic                    head_valid;
   result_type              head_result;
   logic [PAYLOAD_BITS-1:0] head_payload;
   logic [COUNT_W-1:0]      queue_fill;

   // classify events, update the window, access the store
   sws_front #(
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .csr_if       (csr_if),
      .queue_fill   (queue_fill),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .push         (push),
      .push_result  (push_result),
      .push_payload (push_payload)
   );

   // packet store
   sws_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_SPACE)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // decouple front and back
   sws_queue #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_result  (push_result),
      .push_payload (push_payload),
      .pop          (pop),
      .head_valid   (head_valid),
      .head_result  (head_result),
      .head_payload (head_payload),
      .fill         (queue_fill)
   );

   // response output register
   sws_back #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_result  (head_result),
      .head_payload (head_payload),
      .pop          (pop),
      .rsp_if       (rsp_if)
   );

endmodule

// File: rtl/sws_ram.sv
module sws_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/sws_front.sv
module sws_front #(
   parameter int SEQ_SPACE    = 8,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   sws_req_if.sink                          req_if,
   sws_csr_if.sink                          csr_if,
   input  logic [sws_pkg::COUNT_W-1:0]      queue_fill,
   output logic                             ram_we,
   output logic [$clog2(SEQ_SPACE)-1:0]     ram_waddr,
   output logic [PAYLOAD_BITS-1:0]          ram_wdata,
   output logic                             ram_re,
   output logic [$clog2(SEQ_SPACE)-1:0]     ram_raddr,
   input  logic [PAYLOAD_BITS-1:0]          ram_rdata,
   output logic                             push,
   output sws_pkg::result_type              push_result,
   output logic [PAYLOAD_BITS-1:0]          push_payload
);
   import sws_pkg::*;

   localparam int SEQ_W     = $clog2(SEQ_SPACE);
   localparam int SUM_W     = $clog2(SEQ_SPACE + 8);
   localparam int MOD_STEPS = (SEQ_SPACE + 7) / SEQ_SPACE;
   localparam logic [SUM_W-1:0] SPACE_W   = SUM_W'(SEQ_SPACE);
   localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_SPACE - 1);
   localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

   // reduce a small sum modulo the sequence space
   function automatic logic [SUM_W-1:0] seq_mod(input logic [SUM_W-1:0] value);
      logic [SUM_W-1:0] rem;
      rem = value;
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (rem >= SPACE_W) begin
            rem = rem - SPACE_W;
         end
      end
      return rem;
   endfunction

   logic [WIN_W-1:0]        window_size_ff;
   logic [SEQ_W-1:0]        base_ff, base_in;
   logic [SEQ_W-1:0]        next_ff, next_in;
   logic [DUP_W-1:0]        dup_ff, dup_in;
   logic                    s1_valid_ff;
   result_type              s1_result_ff;
   logic                    s1_from_ram_ff;
   logic [PAYLOAD_BITS-1:0] s1_payload_ff;

   logic                    accept;
   result_type              result;
   logic                    from_ram;
   logic                    store_we;
   logic                    store_re;
   logic [SUM_W-1:0]        base_ext, next_ext, end_ext, ack_ext;
   logic [SEQ_W-1:0]        new_base;
   logic [SEQ_W-1:0]        next_inc;
   logic                    window_full;
   logic                    in_window;

   // take a new event while the queue has room for everything in flight
   assign req_if.ready = !reset &&
                         ((queue_fill + COUNT_W'(s1_valid_ff)) < COUNT_W'(QUEUE_DEPTH));
   assign accept       = req_if.valid && req_if.ready;
   assign csr_if.ready = !reset;

   // window arithmetic
   always_comb begin
      base_ext    = SUM_W'(base_ff);
      next_ext    = SUM_W'(next_ff);
      ack_ext     = SUM_W'(req_if.ack_number);
      end_ext     = seq_mod(base_ext + SUM_W'(window_size_ff));
      window_full = (end_ext == next_ext);
      if (base_ext < end_ext) begin
         in_window = (ack_ext >= base_ext) && (ack_ext < end_ext);
      end else begin
         in_window = (ack_ext >= base_ext) || (ack_ext < end_ext);
      end
      new_base = SEQ_W'(seq_mod(ack_ext + SUM_W'(1)));
      next_inc = (next_ff == SEQ_LAST) ? '0 : next_ff + SEQ_W'(1);
   end

   // classify the event and decide the state update
   always_comb begin
      result   = '0;
      from_ram = 1'b0;
      store_we = 1'b0;
      store_re = 1'b0;
      base_in  = base_ff;
      next_in  = next_ff;
      dup_in   = dup_ff;
      unique case (operation_type'(req_if.operation))
         OP_SEND: begin
            if (!window_full) begin
               store_we           = 1'b1;
               result.accepted    = 1'b1;
               result.transmit    = 1'b1;
               result.tx_sequence = TX_SEQ_W'(next_ff);
               result.timer_action = (base_ff == next_ff) ? TIMER_START : TIMER_NONE;
               next_in            = next_inc;
            end
         end
         OP_ACK: begin
            if (req_if.checksum_ok) begin
               if (in_window) begin
                  base_in             = new_base;
                  dup_in              = DUP_RESET;
                  result.ack_kind     = ACK_NEW;
                  result.timer_action = (new_base != next_ff) ? TIMER_RESTART : TIMER_STOP;
               end else begin
                  result.ack_kind = ACK_DUP;
                  if (dup_ff < DUP_LIMIT) begin
                     dup_in = dup_ff + DUP_W'(1);
                     if (dup_in == DUP_LIMIT) begin
                        store_re               = 1'b1;
                        from_ram               = 1'b1;
                        result.transmit        = 1'b1;
                        result.tx_sequence     = TX_SEQ_W'(base_ff);
                        result.fast_retransmit = 1'b1;
                     end
                  end
               end
            end
         end
         OP_TIMEOUT: begin
            store_re            = 1'b1;
            from_ram            = 1'b1;
            result.transmit     = 1'b1;
            result.tx_sequence  = TX_SEQ_W'(base_ff);
            result.timer_action = TIMER_RESTART;
         end
         default: begin
         end
      endcase
   end

   // packet store access
   assign ram_we    = accept && store_we;
   assign ram_waddr = next_ff;
   assign ram_wdata = req_if.payload_word;
   assign ram_re    = accept && store_re;
   assign ram_raddr = base_ff;

   // window state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WIN_RESET;
         base_ff        <= SEQ_RESET;
         next_ff        <= SEQ_RESET;
         dup_ff         <= DUP_RESET;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            window_size_ff <= csr_if.window_size;
         end
         if (accept) begin
            base_ff <= base_in;
            next_ff <= next_in;
            dup_ff  <= dup_in;
         end
         s1_valid_ff <= accept;
      end
   end

   // hold the decision while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff   <= result;
         s1_from_ram_ff <= from_ram;
         s1_payload_ff  <= (store_we) ? req_if.payload_word : '0;
      end
   end

   // hand the finished transaction to the queue
   assign push         = s1_valid_ff;
   assign push_result  = s1_result_ff;
   assign push_payload = s1_from_ram_ff ? ram_rdata : s1_payload_ff;

`ifndef NO_ASSERTIONS
   a_dup_nonzero: assert property (@(posedge clock) disable iff (reset)
      dup_ff != '0)
      else $error("duplicate count left its range");
   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read in the same cycle");
   a_resend_is_tx: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_from_ram_ff |-> s1_result_ff.transmit)
      else $error("store read for a transaction that transmits nothing");
   a_accept_pushes: assert property (@(posedge clock) disable iff (reset)
      accept |=> push)
      else $error("accepted transaction did not reach the queue");
`endif

endmodule

// File: rtl/sws_queue.sv
module sws_queue #(
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sws_pkg::result_type         push_result,
   input  logic [PAYLOAD_BITS-1:0]     push_payload,
   input  logic                        pop,
   output logic                        head_valid,
   output sws_pkg::result_type         head_result,
   output logic [PAYLOAD_BITS-1:0]     head_payload,
   output logic [sws_pkg::COUNT_W-1:0] fill
);
   import sws_pkg::*;

   result_type              result_mem  [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] payload_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0]      fill_ff, fill_in;

   // advance pointers and count
   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fill_ff <= fill_in;
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         result_mem[wr_ptr_ff]  <= push_result;
         payload_mem[wr_ptr_ff] <= push_payload;
      end
   end

   assign head_valid   = (fill_ff != '0);
   assign head_result  = result_mem[rd_ptr_ff];
   assign head_payload = payload_mem[rd_ptr_ff];
   assign fill         = fill_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> fill_ff < COUNT_W'(QUEUE_DEPTH))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> fill_ff != '0)
      else $error("queue underflow");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// File: rtl/sws_back.sv
module sws_back #(
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  sws_pkg::result_type     head_result,
   input  logic [PAYLOAD_BITS-1:0] head_payload,
   output logic                    pop,
   sws_rsp_if.source               rsp_if
);
   import sws_pkg::*;

   logic                    valid_ff, valid_in;
   result_type              result_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;

   // load the output register when it is empty or being taken
   assign pop      = head_valid && (!valid_ff || rsp_if.ready);
   assign valid_in = pop || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff  <= head_result;
         payload_ff <= head_payload;
      end
   end

   // drive the response channel
   assign rsp_if.valid           = valid_ff;
   assign rsp_if.accepted        = result_ff.accepted;
   assign rsp_if.transmit        = result_ff.transmit;
   assign rsp_if.tx_sequence     = result_ff.tx_sequence;
   assign rsp_if.tx_payload      = payload_ff;
   assign rsp_if.timer_action    = result_ff.timer_action;
   assign rsp_if.ack_kind        = result_ff.ack_kind;
   assign rsp_if.fast_retransmit = result_ff.fast_retransmit;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import sws_pkg::*;

   // one event offered on the request channel
   typedef struct packed {
      operation_type op;
      logic [63:0]   payload;
      logic [2:0]    ack;
      logic          ok;
   } window_event_t;

   // one expected response: flag fields plus the transmitted word
   typedef struct packed {
      result_type  flags;
      logic [63:0] payload;
   } tx_report_t;

   // sender bookkeeping: window, counters and the retransmit store
   typedef struct packed {
      logic [WIN_W-1:0]  win;
      logic [2:0]        base;
      logic [2:0]        next_seq;
      logic [DUP_W-1:0]  dup;
      logic [7:0]        written;
      logic [7:0][63:0]  store;
   } sender_state_t;

   // window sizes for the random phases, listed from entry 7 down to entry 0
   localparam logic [7:0][2:0] WINDOW_PLAN =
      {3'd4, 3'd6, 3'd2, 3'd5, 3'd3, 3'd0, 3'd1, 3'd7};
   localparam int RANDOM_PER_PHASE = 66;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sws_req_if #(.PAYLOAD_BITS(64)) req_bus ();
   sws_rsp_if #(.PAYLOAD_BITS(64)) rsp_bus ();
   sws_csr_if                      csr_bus ();

   // testbench-side drivers, known from time zero
   logic          req_valid = 1'b0;
   window_event_t offered   = '0;
   logic          csr_valid = 1'b0;
   logic [2:0]    csr_size  = '0;
   logic          rsp_ready = 1'b0;

   assign req_bus.valid        = req_valid;
   assign req_bus.operation    = offered.op;
   assign req_bus.payload_word = offered.payload;
   assign req_bus.ack_number   = offered.ack;
   assign req_bus.checksum_ok  = offered.ok;
   assign csr_bus.valid        = csr_valid;
   assign csr_bus.window_size  = csr_size;
   assign rsp_bus.ready        = rsp_ready;

   sliding_window_sender #(.SEQ_SPACE(8), .PAYLOAD_BITS(64)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .csr_if (csr_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   window_event_t pending[$];
   tx_report_t    expected_tx[$];
   sender_state_t live_state;
   sender_state_t gen_state;

   bit req_taken      = 1'b0;
   bit live_stale;
   bit long_hold_done = 1'b0;
   int send_idle_pct  = 22;
   int recv_idle_pct  = 79;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int errors         = 0;
   int shown          = 0;
   int events_sent    = 0;
   int results_checked = 0;
   int fast_seen      = 0;
   int settings_done  = 0;

   // compute the response to one event and advance the sender state
   function automatic tx_report_t advance_window(inout sender_state_t st,
                                                 input window_event_t ev,
                                                 output bit stale_read);
      tx_report_t r;
      logic [2:0] wend;
      logic [2:0] b;
      bit         hit;
      r          = '0;
      stale_read = 1'b0;
      wend       = st.base + st.win;
      b          = st.base;
      case (ev.op)
         OP_SEND: begin
            if (wend != st.next_seq) begin
               st.store[st.next_seq]   = ev.payload;
               st.written[st.next_seq] = 1'b1;
               r.flags.accepted        = 1'b1;
               r.flags.transmit        = 1'b1;
               r.flags.tx_sequence     = st.next_seq;
               r.payload               = ev.payload;
               r.flags.timer_action    = (st.base == st.next_seq) ? TIMER_START : TIMER_NONE;
               st.next_seq             = st.next_seq + 3'd1;
            end
         end
         OP_ACK: begin
            if (ev.ok) begin
               if (st.base < wend)
                  hit = (ev.ack >= st.base) && (ev.ack < wend);
               else
                  hit = (ev.ack >= st.base) || (ev.ack < wend);
               if (hit) begin
                  st.base              = ev.ack + 3'd1;
                  st.dup               = DUP_RESET;
                  r.flags.timer_action = (st.base != st.next_seq) ? TIMER_RESTART : TIMER_STOP;
                  r.flags.ack_kind     = ACK_NEW;
               end else begin
                  r.flags.ack_kind = ACK_DUP;
                  // saturate; resend only on the step that reaches the limit
                  if (st.dup < DUP_LIMIT) begin
                     st.dup = st.dup + 2'd1;
                     if (st.dup == DUP_LIMIT) begin
                        r.flags.transmit        = 1'b1;
                        r.flags.tx_sequence     = b;
                        r.payload               = st.store[b];
                        r.flags.fast_retransmit = 1'b1;
                        stale_read              = !st.written[b];
                     end
                  end
               end
            end
         end
         OP_TIMEOUT: begin
            r.flags.transmit     = 1'b1;
            r.flags.tx_sequence  = b;
            r.payload            = st.store[b];
            r.flags.timer_action = TIMER_RESTART;
            stale_read           = !st.written[b];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic window_event_t make_event(operation_type op, logic [63:0] payload,
                                                logic [2:0] ack, logic ok);
      window_event_t ev;
      ev.op      = op;
      ev.payload = payload;
      ev.ack     = ack;
      ev.ok      = ok;
      return ev;
   endfunction

   function automatic logic [63:0] random_payload();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic bit field_mismatch(input string label, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         if (shown < 40)
            $display("%0d ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         shown++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // queue an event; never let a resend read a store entry that was never written
   task automatic queue_event(input window_event_t ev);
      sender_state_t trial;
      bit            stale;
      tx_report_t    unused;
      trial  = gen_state;
      unused = advance_window(trial, ev, stale);
      if (stale) begin
         ev.op  = OP_SEND;
         trial  = gen_state;
         unused = advance_window(trial, ev, stale);
      end
      gen_state = trial;
      pending.push_back(ev);
   endtask

   // mostly well-formed traffic with random content, plus corrupt and unknown events
   task automatic queue_random(input int count);
      window_event_t ev;
      int            pick;
      int            k;
      int            n;
      logic [2:0]    outst;
      logic [2:0]    prior;
      n = 0;
      while (n < count) begin
         ev.op      = OP_SEND;
         ev.payload = random_payload();
         ev.ack     = 3'($urandom_range(0, 7));
         ev.ok      = 1'($urandom_range(0, 1));
         outst      = gen_state.next_seq - gen_state.base;
         prior      = gen_state.base - 3'd1;
         pick       = $urandom_range(0, 99);
         if (pick < 40) begin
            ev.op = OP_SEND;
         end else if (pick < 68) begin
            if (outst != 0) begin
               ev.op  = OP_ACK;
               ev.ok  = 1'b1;
               ev.ack = gen_state.base + 3'($urandom_range(0, outst - 1));
            end
         end else if (pick < 82) begin
            // burst of duplicates on the packet before the base
            k = $urandom_range(1, 3);
            repeat (k - 1) begin
               queue_event(make_event(OP_ACK, random_payload(), prior, 1'b1));
               n++;
            end
            ev.op  = OP_ACK;
            ev.ok  = 1'b1;
            ev.ack = prior;
         end else if (pick < 88) begin
            ev.op = OP_TIMEOUT;
         end else if (pick < 95) begin
            ev.op = OP_ACK;
         end else begin
            ev.op = OP_IGNORE;
         end
         queue_event(ev);
         n++;
      end
   endtask

   task automatic write_window(input logic [2:0] size);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_size  <= size;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      live_state.win = size;
      gen_state.win  = size;
      settings_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every offered event has been answered
   task automatic drain(input int max_cycles);
      int waited;
      waited = 0;
      while ((pending.size() != 0 || req_valid || expected_tx.size() != 0) &&
             waited < max_cycles) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= max_cycles) begin
         errors++;
         $display("%0d ns: %0d expected responses never arrived", $time, expected_tx.size());
      end
      repeat (5) @(posedge clock);
   endtask

   // request driver: offer the next pending event, hold it until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            offered   <= pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict the response of each accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_bus.ready) begin
         expected_tx.push_back(advance_window(live_state, offered, live_stale));
         req_taken = 1'b1;
         events_sent++;
      end
   end

   // response receiver: random stalls, one long hold-off in the no-idle profile
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (recv_idle_pct == 0 && !long_hold_done) begin
         quiet_cycles++;
         if (quiet_cycles == 20) begin
            hold_left      = 60;
            long_hold_done = 1'b1;
         end
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // response monitor: compare with the oldest expectation
   always @(posedge clock) begin
      tx_report_t want;
      bit         bad;
      if (!reset && rsp_bus.valid && rsp_ready) begin
         if (expected_tx.size() == 0) begin
            errors++;
            if (shown < 40)
               $display("%0d ns: response with nothing expected, actual seq %0h payload %0h",
                        $time, rsp_bus.tx_sequence, rsp_bus.tx_payload);
            shown++;
         end else begin
            want = expected_tx.pop_front();
            bad  = 1'b0;
            bad |= field_mismatch("accepted", 64'(want.flags.accepted),
                                  64'(rsp_bus.accepted));
            bad |= field_mismatch("transmit", 64'(want.flags.transmit),
                                  64'(rsp_bus.transmit));
            bad |= field_mismatch("tx_sequence", 64'(want.flags.tx_sequence),
                                  64'(rsp_bus.tx_sequence));
            bad |= field_mismatch("tx_payload", want.payload, rsp_bus.tx_payload);
            bad |= field_mismatch("timer_action", 64'(want.flags.timer_action),
                                  64'(rsp_bus.timer_action));
            bad |= field_mismatch("ack_kind", 64'(want.flags.ack_kind),
                                  64'(rsp_bus.ack_kind));
            bad |= field_mismatch("fast_retransmit", 64'(want.flags.fast_retransmit),
                                  64'(rsp_bus.fast_retransmit));
            if (bad)
               errors++;
            if (want.flags.fast_retransmit)
               fast_seen++;
            results_checked++;
         end
      end
   end

   // stimulus sequence
   initial begin
      int phase;
      live_state          = '0;
      live_state.win      = WIN_RESET;
      live_state.base     = 3'd1;
      live_state.next_seq = 3'd1;
      live_state.dup      = DUP_RESET;
      gen_state           = live_state;

      // directed: fill the window at reset size, refuse, corrupt and duplicate acks,
      // saturation, timeouts with and without packets outstanding, unknown event
      queue_event(make_event(OP_SEND, 64'h0, 3'd0, 1'b0));
      queue_event(make_event(OP_SEND, '1, 3'd7, 1'b1));
      queue_event(make_event(OP_SEND, 64'h5555_5555_5555_5555, 3'd0, 1'b0));
      queue_event(make_event(OP_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd7, 1'b1));
      queue_event(make_event(OP_SEND, 64'h1, 3'd0, 1'b0));
      queue_event(make_event(OP_ACK, '1, 3'd3, 1'b0));
      queue_event(make_event(OP_ACK, 64'h0, 3'd7, 1'b1));
      queue_event(make_event(OP_ACK, 64'h0, 3'd0, 1'b1));
      queue_event(make_event(OP_ACK, 64'h0, 3'd0, 1'b1));
      queue_event(make_event(OP_TIMEOUT, '1, 3'd7, 1'b1));
      queue_event(make_event(OP_ACK, 64'h0, 3'd1, 1'b1));
      queue_event(make_event(OP_IGNORE, {$urandom, $urandom}, 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1))));
      queue_event(make_event(OP_ACK, 64'h0, 3'd4, 1'b1));
      queue_event(make_event(OP_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0));
      queue_event(make_event(OP_ACK, 64'h0, 3'd5, 1'b1));
      queue_event(make_event(OP_SEND, 64'hFEDC_BA98_7654_3210, 3'd0, 1'b0));
      queue_event(make_event(OP_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0));
      queue_event(make_event(OP_SEND, 64'h7FFF_FFFF_FFFF_FFFE, 3'd0, 1'b0));
      queue_event(make_event(OP_ACK, 64'h0, 3'd0, 1'b1));
      queue_event(make_event(OP_TIMEOUT, 64'h0, 3'd0, 1'b0));
      queue_event(make_event(OP_IGNORE, '1, 3'd7, 1'b1));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      drain(20000);

      // random phases: receiver-heavy idling, then sender-heavy, then none
      for (phase = 1; phase <= 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 22;
            recv_idle_pct = 79;
         end else if (phase < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_window(WINDOW_PLAN[phase - 1]);
         queue_random(RANDOM_PER_PHASE);
         drain(20000);
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d responses to %0d events across %0d window size settings",
               results_checked, events_sent, settings_done);
      $display("Fast retransmits seen: %0d, long receiver hold-off %s",
               fast_seen, long_hold_done ? "applied" : "not reached");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
